>>> hw/rtl/sapq_pkg.sv
// ----------------------------------------------------------------------------
// sapq_pkg: shared definitions for the sorted-array priority queue
// Sizes, stream packing offsets, operation and status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sapq_pkg;

  // Queue geometry.
  localparam int DEPTH     = 16;
  localparam int PRIO_BITS = 16;
  localparam int IDX_W     = $clog2(DEPTH);

  // Field widths on the stream channels.
  localparam int MODE_W = 2;
  localparam int TAG_W  = 64;
  localparam int PRI_W  = 16;
  localparam int POS_W  = 5;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  // Both tdata buses carry tag, priority and a 5-bit position or count, padded to bytes.
  localparam int PAYLOAD_W = TAG_W + PRI_W + POS_W;
  localparam int TDATA_W   = ((PAYLOAD_W + 7) / 8) * 8;
  localparam int PAD_W     = TDATA_W - PAYLOAD_W;
  localparam int PRI_LSB   = TAG_W;
  localparam int CNT_LSB   = TAG_W + PRI_W;

  // Operation selected by the input tuser.
  typedef enum logic [MODE_W-1:0] {
    MODE_ENQ  = 2'd0,
    MODE_DEQ  = 2'd1,
    MODE_PEEK = 2'd2,
    MODE_NOP  = 2'd3
  } mode_t;

  // Result status carried on the output tuser.
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef logic signed [PRIO_BITS-1:0] prio_t;

  // One stored queue entry.
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    prio_t            prio;
  } entry_t;

  // Sign-extend a stored priority to the output field width.
  function automatic logic signed [PRI_W-1:0] sext_prio(input prio_t p);
    return PRI_W'(p);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sorted_array_priority_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_array_priority_queue_top: bounded priority queue on a sorted array
// Enqueue, dequeue and peek over a stream interface with one result per item.
// ----------------------------------------------------------------------------
// The queue holds up to DEPTH entries in slot memory, sorted by falling
// priority, with equal priorities kept in arrival order. Positions never wrap,
// so enqueue reports full once the rear has reached the last slot. The block
// takes one operation at a time: in_tready is high only while the sequencer is
// idle. An enqueue into a non-empty queue walks the insertion point down from
// one slot past the rear; each stored entry of lower priority is moved one
// slot up by the single read-compare-write step on the slot memory, one entry
// per cycle. A dequeue or a peek that returns an entry reads the slot memory
// in S_FETCH, and every operation then waits in S_RESP until the output
// register is free. The result waits in an output register, and the next item
// is accepted while it waits.
`timescale 1ns / 1ps
`default_nettype none

module sorted_array_priority_queue_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // Fields from bit 0: item_tag[63:0], item_priority[79:64], position[84:80].
  input  wire logic [sapq_pkg::TDATA_W-1:0] in_tdata,
  // Fields from bit 0: mode[1:0].
  input  wire logic [sapq_pkg::MODE_W-1:0]  in_tuser,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // Fields from bit 0: out_tag[63:0], out_priority[79:64], occupancy[84:80].
  output logic [sapq_pkg::TDATA_W-1:0]      out_tdata,
  // Fields from bit 0: status[1:0].
  output logic [sapq_pkg::STAT_W-1:0]       out_tuser
);
  import sapq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SHIFT = 4'b0010,
    S_FETCH = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    front_r, front_nxt;
  logic [IDX_W-1:0]    rear_r, rear_nxt;
  logic                empty_r, empty_nxt;
  logic [IDX_W-1:0]    j_r, j_nxt;
  logic [TAG_W-1:0]    op_tag_r, op_tag_nxt;
  prio_t               op_prio_r, op_prio_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [TAG_W-1:0]    res_tag_r, res_tag_nxt;
  logic [PRI_W-1:0]    res_prio_r, res_prio_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [TDATA_W-1:0]  out_data_r, out_data_nxt;
  status_t             out_status_r, out_status_nxt;

  // Slot memory with one write and one registered read port.
  entry_t              mem [DEPTH];
  entry_t              rd_r;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  entry_t              wr_data;

  // Input fields.
  mode_t               in_mode;
  logic [TAG_W-1:0]    in_tag;
  prio_t               in_prio;
  logic [POS_W-1:0]    in_pos;
  logic                in_xfer;

  // Derived queue status.
  logic [OCC_W-1:0]    held;
  logic                at_last;
  logic                shift_go;
  logic                out_free;

  assign in_mode = mode_t'(in_tuser);
  assign in_tag  = in_tdata[TAG_W-1:0];
  assign in_prio = prio_t'(in_tdata[PRI_LSB +: PRIO_BITS]);
  assign in_pos  = in_tdata[CNT_LSB +: POS_W];

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign held     = empty_r ? '0 : (OCC_W'(rear_r) - OCC_W'(front_r) + OCC_W'(1));
  assign at_last  = (rear_r == IDX_W'(DEPTH - 1));
  // Move the entry below the insertion point up while it has lower priority.
  assign shift_go = (j_r > front_r) && (rd_r.prio < op_prio_r);

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_r <= mem[rd_addr];
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    rear_nxt       = rear_r;
    empty_nxt      = empty_r;
    j_nxt          = j_r;
    op_tag_nxt     = op_tag_r;
    op_prio_nxt    = op_prio_r;
    res_status_nxt = res_status_r;
    res_tag_nxt    = res_tag_r;
    res_prio_nxt   = res_prio_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    rd_addr        = rear_r;
    wr_en          = 1'b0;
    wr_addr        = j_r;
    wr_data        = rd_r;

    // The output register empties on its own transfer.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_tag_nxt     = in_tag;
          op_prio_nxt    = in_prio;
          res_status_nxt = ST_OK;
          res_tag_nxt    = '0;
          res_prio_nxt   = '0;
          state_nxt      = S_RESP;
          unique case (in_mode)
            MODE_ENQ: begin
              if (empty_r) begin
                // First entry goes to slot zero.
                wr_en     = 1'b1;
                wr_addr   = '0;
                wr_data   = '{tag: in_tag, prio: in_prio};
                front_nxt = '0;
                rear_nxt  = '0;
                empty_nxt = 1'b0;
              end else if (at_last) begin
                res_status_nxt = ST_FULL;
              end else begin
                // Start the insertion walk one slot past the rear.
                rd_addr   = rear_r;
                j_nxt     = rear_r + IDX_W'(1);
                state_nxt = S_SHIFT;
              end
            end
            MODE_DEQ: begin
              if (empty_r) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                rd_addr   = front_r;
                state_nxt = S_FETCH;
                if (front_r == rear_r) begin
                  front_nxt = '0;
                  rear_nxt  = '0;
                  empty_nxt = 1'b1;
                end else begin
                  front_nxt = front_r + IDX_W'(1);
                end
              end
            end
            MODE_PEEK: begin
              if (empty_r) begin
                res_status_nxt = ST_EMPTY;
              end else if ((in_pos == '0) || (in_pos > held)) begin
                res_status_nxt = ST_RANGE;
              end else begin
                rd_addr   = front_r + IDX_W'(in_pos) - IDX_W'(1);
                state_nxt = S_FETCH;
              end
            end
            MODE_NOP: begin
            end
            default: begin
            end
          endcase
        end
      end

      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = j_r;
        if (shift_go) begin
          wr_data   = rd_r;
          j_nxt     = j_r - IDX_W'(1);
          rd_addr   = j_r - IDX_W'(2);
        end else begin
          wr_data   = '{tag: op_tag_r, prio: op_prio_r};
          rear_nxt  = rear_r + IDX_W'(1);
          state_nxt = S_RESP;
        end
      end

      S_FETCH: begin
        res_tag_nxt  = rd_r.tag;
        res_prio_nxt = sext_prio(rd_r.prio);
        state_nxt    = S_RESP;
      end

      S_RESP: begin
        // Occupancy reflects the queue after the operation.
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_data_nxt   = {{PAD_W{1'b0}}, held, res_prio_r, res_tag_r};
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      rear_r      <= '0;
      empty_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      rear_r      <= rear_nxt;
      empty_r     <= empty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    j_r          <= j_nxt;
    op_tag_r     <= op_tag_nxt;
    op_prio_r    <= op_prio_nxt;
    res_status_r <= res_status_nxt;
    res_tag_r    <= res_tag_nxt;
    res_prio_r   <= res_prio_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule

`default_nettype wire

>>> hw/rtl/sapq_checker.sv
// ----------------------------------------------------------------------------
// sapq_checker: port-level assertions for the priority queue
// Watches both stream channels and checks result consistency over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sapq_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_tvalid,
  input wire logic                         in_tready,
  input wire logic [sapq_pkg::TDATA_W-1:0] in_tdata,
  input wire logic [sapq_pkg::MODE_W-1:0]  in_tuser,
  input wire logic                         out_tvalid,
  input wire logic                         out_tready,
  input wire logic [sapq_pkg::TDATA_W-1:0] out_tdata,
  input wire logic [sapq_pkg::STAT_W-1:0]  out_tuser
);
  import sapq_pkg::*;

  logic [OCC_W-1:0] occ;
  logic [TAG_W-1:0] otag;
  logic [PRI_W-1:0] oprio;

  assign occ   = out_tdata[CNT_LSB +: OCC_W];
  assign otag  = out_tdata[TAG_W-1:0];
  assign oprio = out_tdata[PRI_LSB +: PRI_W];

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // The block works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

  // An empty report leaves the queue empty and carries no entry.
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_EMPTY) |-> (occ == '0) && (otag == '0) && (oprio == '0))
    else $error("empty status with entry or nonzero occupancy");

  // Full and out-of-range reports carry no entry and both imply a held entry.
  a_refused_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tuser == ST_FULL) || (out_tuser == ST_RANGE))
      |-> (occ != '0) && (otag == '0) && (oprio == '0))
    else $error("refused operation returned an entry");

  // Occupancy never exceeds the number of slots.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (occ <= OCC_W'(DEPTH)))
    else $error("occupancy above depth");

endmodule

bind sorted_array_priority_queue_top sapq_checker u_sapq_checker (.*);

`default_nettype wire

>>> dv/sapq_result_checker.sv
// ----------------------------------------------------------------------------
// sapq_result_checker: result prediction and comparison for the priority queue
// Watches both stream channels, keeps its own sorted-array image of the queue,
// predicts the result of every accepted operation and compares each result
// transfer with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sapq_result_checker (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  input  wire logic                         in_tready,
  // Fields from bit 0: item_tag[63:0], item_priority[79:64], position[84:80].
  input  wire logic [sapq_pkg::TDATA_W-1:0] in_tdata,
  // Fields from bit 0: mode[1:0].
  input  wire logic [sapq_pkg::MODE_W-1:0]  in_tuser,
  input  wire logic                         out_tvalid,
  input  wire logic                         out_tready,
  // Fields from bit 0: out_tag[63:0], out_priority[79:64], occupancy[84:80].
  input  wire logic [sapq_pkg::TDATA_W-1:0] out_tdata,
  // Fields from bit 0: status[1:0].
  input  wire logic [sapq_pkg::STAT_W-1:0]  out_tuser,
  output int                                fail_count,
  output int                                pending,
  output int                                checked,
  output int                                n_full,
  output int                                n_empty,
  output int                                n_range
);

  import sapq_pkg::*;

  localparam int MAX_SHOWN = 30;

  // One predicted result transfer.
  typedef struct packed {
    status_t          status;
    logic [TAG_W-1:0] tag;
    prio_t            prio;
    logic [OCC_W-1:0] occ;
  } op_result_t;

  // Image of the queue: slots in falling priority between head and tail.
  logic [TAG_W-1:0] slot_tag [DEPTH];
  prio_t            slot_prio [DEPTH];
  int               head_slot;
  int               tail_slot;
  bit               is_empty;

  op_result_t awaited_results [$];
  int         shown;

  function automatic int entries_held();
    return is_empty ? 0 : tail_slot - head_slot + 1;
  endfunction

  // Applies one operation to the queue image and returns its result.
  function automatic op_result_t apply_queue_op(input mode_t m,
                                                input logic [TAG_W-1:0] tag,
                                                input prio_t pri,
                                                input logic [POS_W-1:0] pos);
    op_result_t r;
    int         j;
    r = '0;
    r.status = ST_OK;
    case (m)
      MODE_ENQ: begin
        if (is_empty) begin
          head_slot = 0;
          tail_slot = 0;
          slot_tag[0] = tag;
          slot_prio[0] = pri;
          is_empty = 1'b0;
        end else if (tail_slot >= DEPTH - 1) begin
          // The positions never wrap, so freed slots at the head do not help.
          r.status = ST_FULL;
        end else begin
          // Shift lower priorities up; equal priorities stay ahead.
          j = tail_slot + 1;
          while (j > head_slot && slot_prio[j-1] < pri) begin
            slot_tag[j] = slot_tag[j-1];
            slot_prio[j] = slot_prio[j-1];
            j--;
          end
          slot_tag[j] = tag;
          slot_prio[j] = pri;
          tail_slot++;
        end
      end
      MODE_DEQ: begin
        if (is_empty) begin
          r.status = ST_EMPTY;
        end else begin
          r.tag = slot_tag[head_slot];
          r.prio = slot_prio[head_slot];
          if (head_slot == tail_slot) begin
            head_slot = 0;
            tail_slot = 0;
            is_empty = 1'b1;
          end else begin
            head_slot++;
          end
        end
      end
      MODE_PEEK: begin
        if (is_empty) begin
          r.status = ST_EMPTY;
        end else if (pos == '0 || int'(pos) > entries_held()) begin
          r.status = ST_RANGE;
        end else begin
          j = head_slot + int'(pos) - 1;
          r.tag = slot_tag[j];
          r.prio = slot_prio[j];
        end
      end
      default: begin
      end
    endcase
    r.occ = OCC_W'(entries_held());
    return r;
  endfunction

  task automatic check_field(input string name, input logic [TAG_W-1:0] expv,
                             input logic [TAG_W-1:0] actv);
    if (expv !== actv) begin
      fail_count++;
      if (shown < MAX_SHOWN) begin
        shown++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, expv, actv);
      end
    end
  endtask

  // Results are compared before the new operation is predicted, so that a
  // result can never be matched against the operation accepted at its edge.
  always @(posedge clk) begin
    op_result_t exp_r;
    if (!rst_n) begin
      head_slot = 0;
      tail_slot = 0;
      is_empty = 1'b1;
      awaited_results.delete();
      shown = 0;
      fail_count = 0;
      checked = 0;
      n_full = 0;
      n_empty = 0;
      n_range = 0;
      pending <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          fail_count++;
          if (shown < MAX_SHOWN) begin
            shown++;
            $display("%0t: unexpected result, expected none, got status %0d data %0h",
                     $time, out_tuser, out_tdata);
          end
        end else begin
          exp_r = awaited_results.pop_front();
          checked++;
          check_field("status", TAG_W'(exp_r.status), TAG_W'(out_tuser));
          check_field("out_tag", exp_r.tag, out_tdata[TAG_W-1:0]);
          // The priority field is compared as raw bits, without sign extension.
          check_field("out_priority", {{(TAG_W-PRI_W){1'b0}}, exp_r.prio},
                      TAG_W'(out_tdata[PRI_LSB +: PRI_W]));
          check_field("occupancy", TAG_W'(exp_r.occ), TAG_W'(out_tdata[CNT_LSB +: OCC_W]));
          case (exp_r.status)
            ST_FULL:  n_full++;
            ST_EMPTY: n_empty++;
            ST_RANGE: n_range++;
            default: begin
            end
          endcase
        end
      end
      if (in_tvalid && in_tready) begin
        awaited_results.push_back(apply_queue_op(mode_t'(in_tuser),
                                                 in_tdata[TAG_W-1:0],
                                                 prio_t'(in_tdata[PRI_LSB +: PRI_W]),
                                                 in_tdata[CNT_LSB +: POS_W]));
      end
      pending <= awaited_results.size();
    end
  end

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the sorted-array priority queue
// Drives directed and random enqueue, dequeue, peek and idle operations in
// bursts against a stalling receiver; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  import sapq_pkg::*;

  localparam int N_RANDOM     = 680;
  localparam int PHASE_LEN    = 40;
  localparam int HOLD_CYCLES  = 80;
  localparam int HOLD_AFTER   = 150;
  localparam int DRAIN_CYCLES = 24;
  localparam int STALL_LIMIT  = 2000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata = '0;
  logic [MODE_W-1:0]  in_tuser = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]  out_tuser;

  int fail_count;
  int pending;
  int checked;
  int n_full;
  int n_empty;
  int n_range;

  int burst_left = 0;
  int idle_cycles = 0;
  int n_enq = 0;
  int n_deq = 0;
  int n_peek = 0;
  int n_nop = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  sorted_array_priority_queue_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  sapq_result_checker results (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .n_full     (n_full),
    .n_empty    (n_empty),
    .n_range    (n_range)
  );

  // A mix of a few close values so that ties are common, full-range values, and the extremes.
  function automatic prio_t rand_prio();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return prio_t'(int'($urandom_range(0, 6)) - 3);
    if (r < 8) return prio_t'($urandom);
    if (r == 8) return prio_t'(16'h7FFF);
    return prio_t'(16'h8000);
  endfunction

  // Offers one operation and returns at the edge of its transfer. A new burst
  // starts with a random gap, sometimes none at all.
  task automatic send_op(input mode_t m, input logic [TAG_W-1:0] tag,
                         input prio_t pri, input logic [POS_W-1:0] pos);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= m;
    in_tdata <= {{PAD_W{1'b0}}, pos, pri, tag};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    case (m)
      MODE_ENQ:  n_enq++;
      MODE_DEQ:  n_deq++;
      MODE_PEEK: n_peek++;
      default:   n_nop++;
    endcase
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Receiver: segments of different stall patterns, and one long hold-off
  // once enough results have been taken so the block backs up its input.
  initial begin
    int  seg_len;
    int  seg_kind;
    int  taken;
    bit  held_off;
    taken = 0;
    held_off = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      seg_kind = $urandom_range(0, 3);
      seg_len = $urandom_range(5, 60);
      repeat (seg_len) begin
        if (!held_off && taken >= HOLD_AFTER) begin
          held_off = 1'b1;
          out_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (seg_kind)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= ($urandom_range(0, 4) != 0);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
        if (out_tvalid && out_tready) taken++;
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    mode_t            m;
    logic [POS_W-1:0] pos;
    int               roll;
    int               enq_lim;
    int               deq_lim;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Operations on the empty queue.
    send_op(MODE_DEQ, 64'h0, prio_t'(0), 5'd1);
    send_op(MODE_PEEK, 64'h0, prio_t'(0), 5'd1);
    send_op(MODE_NOP, 64'hFFFF_FFFF_FFFF_FFFF, prio_t'(16'h8000), 5'd31);

    // Priority extremes and a tie that must keep arrival order.
    send_op(MODE_ENQ, 64'hFFFF_FFFF_FFFF_FFFF, prio_t'(16'h7FFF), 5'd0);
    send_op(MODE_ENQ, 64'h0, prio_t'(16'h8000), 5'd31);
    send_op(MODE_ENQ, 64'h0123_4567_89AB_CDEF, prio_t'(0), 5'd0);
    send_op(MODE_ENQ, 64'hFEDC_BA98_7654_3210, prio_t'(0), 5'd0);

    // Peek at position zero, inside, and one above the occupancy.
    send_op(MODE_PEEK, 64'h0, prio_t'(0), 5'd0);
    send_op(MODE_PEEK, 64'h0, prio_t'(0), 5'd3);
    send_op(MODE_PEEK, 64'h0, prio_t'(0), 5'd5);

    // Fill every slot, then check that a freed head slot is not reused.
    for (int i = 0; i < DEPTH - 4; i++) begin
      send_op(MODE_ENQ, {$urandom, $urandom}, rand_prio(), 5'd0);
    end
    send_op(MODE_ENQ, {$urandom, $urandom}, rand_prio(), 5'd0);
    send_op(MODE_PEEK, 64'h0, prio_t'(0), 5'(DEPTH));
    send_op(MODE_DEQ, 64'h0, prio_t'(0), 5'd0);
    send_op(MODE_ENQ, {$urandom, $urandom}, prio_t'(16'h7FFF), 5'd0);
    send_op(MODE_PEEK, 64'h0, prio_t'(0), 5'(DEPTH));
    wait_drained();

    // Random phases that lean toward filling, draining, or neither.
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) wait_drained();
      case ((i / PHASE_LEN) % 3)
        0: begin
          enq_lim = 60;
          deq_lim = 75;
        end
        1: begin
          enq_lim = 20;
          deq_lim = 70;
        end
        default: begin
          enq_lim = 40;
          deq_lim = 70;
        end
      endcase
      roll = $urandom_range(0, 99);
      m = (roll < enq_lim) ? MODE_ENQ :
          (roll < deq_lim) ? MODE_DEQ :
          (roll < 95)      ? MODE_PEEK : MODE_NOP;
      pos = ($urandom_range(0, 3) == 0) ? POS_W'($urandom_range(0, 31))
                                        : POS_W'($urandom_range(0, DEPTH + 1));
      send_op(m, {$urandom, $urandom}, rand_prio(), pos);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d enqueues, %0d dequeues, %0d peeks and %0d idle operations.",
             n_enq, n_deq, n_peek, n_nop);
    $display("Checked %0d results, with %0d full, %0d empty and %0d out-of-range refusals.",
             checked, n_full, n_empty, n_range);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
